/* rtl/dtst_pkg.sv */
// Package with the microprogram tables, condition codes and shared types of the sequencers.
`timescale 1ns / 1ps

package dtst_pkg;

    // Table lengths of the two sequencers.
    localparam int SEQ_ONE_LEN = 13;
    localparam int SEQ_TWO_LEN = 15;

    // Fixed timer loads of the second sequencer, in tenths of a second.
    localparam logic [7:0] LOAD_LONG  = 8'd30;
    localparam logic [7:0] LOAD_SHORT = 8'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_PERIOD_ONE   = 2'd0;
    localparam logic [1:0] REG_PERIOD_TWO   = 2'd1;
    localparam logic [1:0] REG_PERIOD_THREE = 2'd2;

    // Condition select codes of the first sequencer.
    localparam logic [3:0] SA_NEVER   = 4'd0;
    localparam logic [3:0] SA_ALWAYS  = 4'd1;
    localparam logic [3:0] SA_S3      = 4'd2;
    localparam logic [3:0] SA_T1_DONE = 4'd3;
    localparam logic [3:0] SA_NOT_S4  = 4'd4;
    localparam logic [3:0] SA_S3_ALT  = 4'd5;
    localparam logic [3:0] SA_NOT_S3  = 4'd6;
    localparam logic [3:0] SA_S4      = 4'd7;

    // Condition select codes of the second sequencer.
    localparam logic [3:0] SB_NEVER          = 4'd0;
    localparam logic [3:0] SB_ALWAYS         = 4'd1;
    localparam logic [3:0] SB_S1             = 4'd2;
    localparam logic [3:0] SB_S2             = 4'd3;
    localparam logic [3:0] SB_T2_DONE_NOMODE = 4'd4;
    localparam logic [3:0] SB_MODE           = 4'd5;
    localparam logic [3:0] SB_NOT_S1         = 4'd6;
    localparam logic [3:0] SB_T2_DONE        = 4'd7;
    localparam logic [3:0] SB_T2_DONE_MODE   = 4'd8;

    // Microprogram of the first sequencer: control word, condition select, jump target.
    localparam logic [3:0] WORD_A [SEQ_ONE_LEN] =
        '{4'd12, 4'd10, 4'd8, 4'd5, 4'd4, 4'd4, 4'd4, 4'd10, 4'd8, 4'd12, 4'd8, 4'd0, 4'd12};
    localparam logic [3:0] SEL_A [SEQ_ONE_LEN] =
        '{4'd2, 4'd1, 4'd3, 4'd1, 4'd4, 4'd5, 4'd3, 4'd1, 4'd6, 4'd0, 4'd7, 4'd6, 4'd0};
    localparam logic [3:0] JUMP_A [SEQ_ONE_LEN] =
        '{4'd0, 4'd0, 4'd10, 4'd0, 4'd11, 4'd0, 4'd4, 4'd0, 4'd2, 4'd0, 4'd8, 4'd11, 4'd0};

    // Microprogram of the second sequencer.
    localparam logic [5:0] WORD_B [SEQ_TWO_LEN] =
        '{6'd32, 6'd36, 6'd32, 6'd9, 6'd8, 6'd8, 6'd16, 6'd32, 6'd32, 6'd2, 6'd0,
          6'd36, 6'd32, 6'd8, 6'd16};
    localparam logic [3:0] SEL_B [SEQ_TWO_LEN] =
        '{4'd2, 4'd1, 4'd3, 4'd1, 4'd4, 4'd5, 4'd6, 4'd0, 4'd7, 4'd1, 4'd7, 4'd1, 4'd0,
          4'd8, 4'd0};
    localparam logic [3:0] JUMP_B [SEQ_TWO_LEN] =
        '{4'd0, 4'd0, 4'd8, 4'd0, 4'd13, 4'd5, 4'd6, 4'd0, 4'd2, 4'd0, 4'd10, 4'd0, 4'd8,
          4'd4, 4'd6};

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        logic [3:0] counter_one;
        logic [3:0] counter_two;
        logic [6:0] timer_one;
        logic [7:0] timer_two;
    } seq_state_t;

    // Configured periods.
    typedef struct packed {
        logic [3:0] period_one;
        logic [3:0] period_two;
        logic [4:0] period_three;
    } seq_cfg_t;

    // Table lookups; an address beyond a table reads as all zero.
    function automatic logic [3:0] word_a(input logic [3:0] pc);
        return (32'(pc) < SEQ_ONE_LEN) ? WORD_A[pc] : 4'd0;
    endfunction

    function automatic logic [3:0] sel_a(input logic [3:0] pc);
        return (32'(pc) < SEQ_ONE_LEN) ? SEL_A[pc] : SA_NEVER;
    endfunction

    function automatic logic [3:0] jump_a(input logic [3:0] pc);
        return (32'(pc) < SEQ_ONE_LEN) ? JUMP_A[pc] : 4'd0;
    endfunction

    function automatic logic [5:0] word_b(input logic [3:0] pc);
        return (32'(pc) < SEQ_TWO_LEN) ? WORD_B[pc] : 6'd0;
    endfunction

    function automatic logic [3:0] sel_b(input logic [3:0] pc);
        return (32'(pc) < SEQ_TWO_LEN) ? SEL_B[pc] : SB_NEVER;
    endfunction

    function automatic logic [3:0] jump_b(input logic [3:0] pc);
        return (32'(pc) < SEQ_TWO_LEN) ? JUMP_B[pc] : 4'd0;
    endfunction

endpackage

/* rtl/dtst_step.sv */
// One tick of both sequencers: table lookup, condition select, branch and timer update.
`timescale 1ns / 1ps

module dtst_step (
    input  dtst_pkg::seq_state_t state,
    input  dtst_pkg::seq_cfg_t   cfg,
    input  logic [4:0]           switches,   // switch_one, switch_two, switch_three,
                                             // switch_four, mode_flag from bit 0 up
    output dtst_pkg::seq_state_t state_next,
    output logic [31:0]          result      // output word, packed as on the master side
);

    // Period times ten, saturated to the first timer's range.
    function automatic logic [6:0] load_one(input logic [3:0] p);
        logic [7:0] v;
        v = {1'b0, p, 3'b000} + {3'b000, p, 1'b0};
        return (v > 8'd127) ? 7'h7F : v[6:0];
    endfunction

    // Period times ten, saturated to the second timer's range.
    function automatic logic [7:0] load_two(input logic [4:0] p);
        logic [8:0] v;
        v = {1'b0, p, 3'b000} + {3'b000, p, 1'b0};
        return (v > 9'd255) ? 8'hFF : v[7:0];
    endfunction

    logic       s1;
    logic       s2;
    logic       s3;
    logic       s4;
    logic       mode;
    logic [3:0] wa;
    logic [3:0] sa;
    logic [3:0] ja;
    logic [5:0] wb;
    logic [3:0] sb;
    logic [3:0] jb;
    logic       cond_a;
    logic       cond_b;
    logic [6:0] t1;
    logic [7:0] t2;

    assign s1   = switches[0];
    assign s2   = switches[1];
    assign s3   = switches[2];
    assign s4   = switches[3];
    assign mode = switches[4];

    assign wa = dtst_pkg::word_a(state.counter_one);
    assign sa = dtst_pkg::sel_a(state.counter_one);
    assign ja = dtst_pkg::jump_a(state.counter_one);
    assign wb = dtst_pkg::word_b(state.counter_two);
    assign sb = dtst_pkg::sel_b(state.counter_two);
    assign jb = dtst_pkg::jump_b(state.counter_two);

    // Branch condition of the first sequencer; timers are seen before this tick's load.
    always_comb
    begin
        case (sa) inside
            dtst_pkg::SA_NEVER:                     cond_a = 1'b0;
            dtst_pkg::SA_ALWAYS:                    cond_a = 1'b1;
            dtst_pkg::SA_S3, dtst_pkg::SA_S3_ALT:   cond_a = s3;
            dtst_pkg::SA_T1_DONE:                   cond_a = (state.timer_one == 7'd0);
            dtst_pkg::SA_NOT_S4:                    cond_a = !s4;
            dtst_pkg::SA_NOT_S3:                    cond_a = !s3;
            dtst_pkg::SA_S4:                        cond_a = s4;
            default:                                cond_a = 1'b0;
        endcase
    end

    // Branch condition of the second sequencer.
    always_comb
    begin
        case (sb)
            dtst_pkg::SB_NEVER:          cond_b = 1'b0;
            dtst_pkg::SB_ALWAYS:         cond_b = 1'b1;
            dtst_pkg::SB_S1:             cond_b = s1;
            dtst_pkg::SB_S2:             cond_b = s2;
            dtst_pkg::SB_T2_DONE_NOMODE: cond_b = (state.timer_two == 8'd0) && !mode;
            dtst_pkg::SB_MODE:           cond_b = mode;
            dtst_pkg::SB_NOT_S1:         cond_b = !s1;
            dtst_pkg::SB_T2_DONE:        cond_b = (state.timer_two == 8'd0);
            dtst_pkg::SB_T2_DONE_MODE:   cond_b = (state.timer_two == 8'd0) && mode;
            default:                     cond_b = 1'b0;
        endcase
    end

    // Timer loads, the later one winning, then a countdown of a nonzero timer.
    always_comb
    begin
        t1 = state.timer_one;
        if (wa[1])
        begin
            t1 = load_one(cfg.period_one);
        end
        if (wa[0])
        begin
            t1 = load_one(cfg.period_two);
        end
        if (t1 != 7'd0)
        begin
            t1 = t1 - 7'd1;
        end

        t2 = state.timer_two;
        if (wb[2])
        begin
            t2 = dtst_pkg::LOAD_LONG;
        end
        if (wb[1])
        begin
            t2 = dtst_pkg::LOAD_SHORT;
        end
        if (wb[0])
        begin
            t2 = load_two(cfg.period_three);
        end
        if (t2 != 8'd0)
        begin
            t2 = t2 - 8'd1;
        end
    end

    // Advance on a true condition, else jump.
    assign state_next.counter_one = cond_a ? (state.counter_one + 4'd1) : ja;
    assign state_next.counter_two = cond_b ? (state.counter_two + 4'd1) : jb;
    assign state_next.timer_one   = t1;
    assign state_next.timer_two   = t2;

    // Result word: lamps from the words at the old counters, counters and timers after the step.
    assign result = {4'd0, t2, t1, state_next.counter_two, state_next.counter_one,
                     wb[3], wb[4], wb[5], wa[2], wa[3]};

endmodule

/* rtl/dual_table_sequencer_timers.sv */
// Top level: configuration registers, sequencer state and a two-word output queue.
// The result of an accepted word is registered into the output queue and offered on the master side from there.
// Throughput: one word per cycle while the queue has room; the next-state logic of both sequencers is combinational.
// The two-entry output queue keeps accepting while one result waits to be taken.
// Reset clears both counters and timers, empties the queue and sets the periods to 3, 1, 10.
`timescale 1ns / 1ps

module dual_table_sequencer_timers (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Slave side.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // switch_one, switch_two, switch_three, switch_four,
                                   // mode_flag, three zero bits
    // Master side.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // lamp_one, lamp_two, lamp_three, lamp_four, lamp_five,
                                   // step_one[3:0], step_two[3:0], count_one[6:0],
                                   // count_two[7:0], four zero bits
);

    dtst_pkg::seq_cfg_t   cfg_reg;
    dtst_pkg::seq_state_t state_reg;
    dtst_pkg::seq_state_t state_next;
    logic [31:0]          result_next;
    logic [31:0]          buf0_reg;
    logic [31:0]          buf1_reg;
    logic [1:0]           count_reg;
    logic                 push;
    logic                 pop;
    logic                 cfg_write;

    // Configuration writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_one   <= 4'd3;
            cfg_reg.period_two   <= 4'd1;
            cfg_reg.period_three <= 5'd10;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                dtst_pkg::REG_PERIOD_ONE:   cfg_reg.period_one   <= pwdata[3:0];
                dtst_pkg::REG_PERIOD_TWO:   cfg_reg.period_two   <= pwdata[3:0];
                dtst_pkg::REG_PERIOD_THREE: cfg_reg.period_three <= pwdata[4:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dtst_pkg::REG_PERIOD_ONE:   prdata = {28'd0, cfg_reg.period_one};
            dtst_pkg::REG_PERIOD_TWO:   prdata = {28'd0, cfg_reg.period_two};
            dtst_pkg::REG_PERIOD_THREE: prdata = {27'd0, cfg_reg.period_three};
            default:                    prdata = 32'd0;
        endcase
    end

    // Next state and result of one tick.
    dtst_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .switches   (s_tdata[4:0]),
        .state_next (state_next),
        .result     (result_next)
    );

    // Handshakes.
    assign s_tready = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = buf0_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    // Sequencer state advances on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (push)
        begin
            state_reg <= state_next;
        end
    end

    // Queue fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Queue payload; the head is always the oldest word.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf0_reg <= (push && count_reg == 2'd1) ? result_next : buf1_reg;
        end
        else if (push && count_reg == 2'd0)
        begin
            buf0_reg <= result_next;
        end

        if (push && (count_reg == 2'd1) && !pop)
        begin
            buf1_reg <= result_next;
        end
    end

endmodule
